// ===== design/cxs_pkg.sv =====
// ----------------------------------------------------------------------------
// cxs_pkg
// Shared constants and elaboration-time functions for the CIE xy to sRGB
// pipeline: divider step size, matrix coefficients and the gamma threshold ROM.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cxs_pkg;

    // quotient bits resolved per divider pipeline stage
    localparam int DIV_STEP_BITS = 4;

    // number of binary search steps through the gamma ROM (8-bit output code)
    localparam int GAMMA_CODE_BITS = 8;

    // sRGB matrix in ten-thousandths, row-major (R, G, B rows; X, Y, Z columns)
    localparam int MATRIX_TENK [9] = '{
        32406, -15372, -4986,
        -9689,  18758,   415,
          557,  -2040, 10570
    };

    localparam longint COEF_DEN   = 10000;
    localparam longint COEF_ROUND = 5000;

    // inverse transfer curve constants, Q30
    localparam logic [63:0] THR_LIN_DEN = 64'd32946;
    localparam logic [63:0] THR_POW_DEN = 64'd269025;
    localparam logic [63:0] THR_POW_OFS = 64'd14025;
    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;

    typedef logic [30:0] gamma_thr_t [256];

    // matrix coefficient to Q.frac, rounded half up in magnitude
    function automatic longint coef_q(input int tenk, input int frac);
        longint m;
        longint q;
        m = (tenk < 0) ? longint'(-tenk) : longint'(tenk);
        q = ((m << frac) + COEF_ROUND) / COEF_DEN;
        return (tenk < 0) ? -q : q;
    endfunction

    function automatic logic [63:0] mul30(input logic [63:0] a, input logic [63:0] b);
        return (a * b) >> 30;
    endfunction

    function automatic logic [63:0] pow5_30(input logic [63:0] r);
        logic [63:0] r2;
        logic [63:0] r4;
        r2 = mul30(r, r);
        r4 = mul30(r2, r2);
        return mul30(r4, r);
    endfunction

    // largest r with r^5 <= a, Q30 bisection
    function automatic logic [63:0] root5_30(input logic [63:0] a);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        lo = 64'd0;
        hi = Q30_ONE + 64'd1;
        for (int n = 0; n < 32; n++) begin
            if (hi - lo > 64'd1) begin
                mid = lo + ((hi - lo) >> 1);
                if (pow5_30(mid) <= a) begin
                    lo = mid;
                end else begin
                    hi = mid;
                end
            end
        end
        return lo;
    endfunction

    // threshold of each output code on the linear axis, Q30
    function automatic gamma_thr_t build_gamma_thr();
        gamma_thr_t  tab;
        logic [63:0] u;
        logic [63:0] u2;
        logic [63:0] v;
        tab[0] = '0;
        for (int n = 1; n < 256; n++) begin
            v = 64'(n);
            if (n <= 10) begin
                tab[n] = 31'(((v * 64'd10) << 30) / THR_LIN_DEN);
            end else begin
                u      = ((64'd1000 * v + THR_POW_OFS) << 30) / THR_POW_DEN;
                u2     = mul30(u, u);
                tab[n] = 31'(mul30(u2, root5_30(u2)));
            end
        end
        return tab;
    endfunction

    localparam gamma_thr_t GAMMA_THR = build_gamma_thr();

endpackage

// ===== design/cxs_prescale.sv =====
// ----------------------------------------------------------------------------
// cxs_prescale
// Input stage: floors y, converts x and y from 1/65535 units and brightness
// from 1/254 units to Q.FRAC_BITS by reciprocal multiply with one correction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cxs_prescale #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [15:0]          chroma_x,
    input  logic [15:0]          chroma_y,
    input  logic [7:0]           brightness,
    output logic                 out_valid,
    output logic [FRAC_BITS:0]   fx,
    output logic [FRAC_BITS:0]   fy,
    output logic [FRAC_BITS:0]   lum
);
    import cxs_pkg::*;

    localparam int F  = FRAC_BITS;
    localparam int TW = 16 + F;
    localparam int TB = 7 + F;
    localparam logic [15:0]   Y_FLOOR  = 16'd7;
    localparam logic [TW+1:0] DEN_XY   = (TW+2)'(65535);
    localparam logic [TB+1:0] DEN_LUM  = (TB+2)'(127);

    logic              valid_reg;
    logic [F:0]        fx_reg;
    logic [F:0]        fy_reg;
    logic [F:0]        lum_reg;
    logic [F:0]        fx_next;
    logic [F:0]        fy_next;
    logic [F:0]        lum_next;
    logic [15:0]       y_floored;

    // floor(v * 2^F / 65535)
    function automatic logic [F:0] frac16(input logic [15:0] v);
        logic [TW-1:0] t;
        logic [TW:0]   sum;
        logic [F:0]    q1;
        logic [TW+1:0] r;
        t   = {v, {F{1'b0}}};
        sum = {1'b0, t} + (TW+1)'(t >> 16) + (TW+1)'(t >> 32);
        q1  = sum[TW:16];
        r   = (TW+2)'(t) + (TW+2)'(q1) - ((TW+2)'(q1) << 16);
        return q1 + (F+1)'(r >= DEN_XY);
    endfunction

    // floor(b * 2^F / 254) = floor(b * 2^(F-1) / 127)
    function automatic logic [F:0] frac254(input logic [7:0] b);
        logic [TB-1:0] t;
        logic [TB:0]   sum;
        logic [F:0]    q1;
        logic [TB+1:0] r;
        t   = {b, {(F-1){1'b0}}};
        sum = {1'b0, t} + (TB+1)'(t >> 7) + (TB+1)'(t >> 14) + (TB+1)'(t >> 21)
            + (TB+1)'(t >> 28) + (TB+1)'(t >> 35);
        q1  = sum[TB:7];
        r   = (TB+2)'(t) + (TB+2)'(q1) - ((TB+2)'(q1) << 7);
        return q1 + (F+1)'(r >= DEN_LUM);
    endfunction

    // tiny y clamp and fraction conversion
    always_comb begin
        y_floored = (chroma_y < Y_FLOOR) ? Y_FLOOR : chroma_y;
        fx_next   = frac16(chroma_x);
        fy_next   = frac16(y_floored);
        lum_next  = frac254(brightness);
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            fx_reg  <= fx_next;
            fy_reg  <= fy_next;
            lum_reg <= lum_next;
        end
    end

    assign out_valid = valid_reg;
    assign fx        = fx_reg;
    assign fy        = fy_reg;
    assign lum       = lum_reg;

endmodule

// ===== design/cxs_div.sv =====
// ----------------------------------------------------------------------------
// cxs_div
// Pipelined restoring divider for q = floor(Y * 2^F / y), DIV_STEP_BITS
// quotient bits per stage, with the saturation test done up front.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cxs_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [FRAC_BITS:0]          fx,
    input  logic [FRAC_BITS:0]          fy,
    input  logic [FRAC_BITS:0]          lum,
    output logic                        out_valid,
    output logic [FRAC_BITS+7:0]        quo,
    output logic                        ovf,
    output logic [FRAC_BITS:0]          out_fx,
    output logic signed [FRAC_BITS+1:0] out_fz,
    output logic [FRAC_BITS:0]          out_lum
);
    import cxs_pkg::*;

    localparam int F    = FRAC_BITS;
    localparam int S    = F + 8;
    localparam int NDIV = (S + DIV_STEP_BITS - 1) / DIV_STEP_BITS;

    logic               valid_reg [NDIV];
    logic [F:0]         rem_reg   [NDIV];
    logic [S-1:0]       quo_reg   [NDIV];
    logic [7:0]         nb_reg    [NDIV];
    logic [F:0]         d_reg     [NDIV];
    logic [F:0]         fx_reg    [NDIV];
    logic signed [F+1:0] fz_reg   [NDIV];
    logic [F:0]         lum_reg   [NDIV];
    logic               ovf_reg   [NDIV];

    logic [F:0]         rem_next  [NDIV];
    logic [S-1:0]       quo_next  [NDIV];
    logic [7:0]         nb_next   [NDIV];

    logic               valid_in  [NDIV];
    logic [F:0]         rem_in    [NDIV];
    logic [S-1:0]       quo_in    [NDIV];
    logic [7:0]         nb_in     [NDIV];
    logic [F:0]         d_in      [NDIV];
    logic [F:0]         fx_in     [NDIV];
    logic signed [F+1:0] fz_in    [NDIV];
    logic [F:0]         lum_in    [NDIV];
    logic               ovf_in    [NDIV];

    for (genvar s = 0; s < NDIV; s++) begin : g_stage
        // stage inputs: first stage also derives z and the saturation flag
        if (s == 0) begin : g_first
            assign valid_in[0] = in_valid;
            assign rem_in[0]   = (F+1)'(lum[F:8]);
            assign quo_in[0]   = '0;
            assign nb_in[0]    = lum[7:0];
            assign d_in[0]     = fy;
            assign fx_in[0]    = fx;
            assign fz_in[0]    = $signed({2'b01, {F{1'b0}}}) - $signed({1'b0, fx})
                               - $signed({1'b0, fy});
            assign lum_in[0]   = lum;
            assign ovf_in[0]   = (F+9)'(lum) >= {fy, 8'b0};
        end else begin : g_next
            assign valid_in[s] = valid_reg[s-1];
            assign rem_in[s]   = rem_reg[s-1];
            assign quo_in[s]   = quo_reg[s-1];
            assign nb_in[s]    = nb_reg[s-1];
            assign d_in[s]     = d_reg[s-1];
            assign fx_in[s]    = fx_reg[s-1];
            assign fz_in[s]    = fz_reg[s-1];
            assign lum_in[s]   = lum_reg[s-1];
            assign ovf_in[s]   = ovf_reg[s-1];
        end

        // restoring steps of this stage
        always_comb begin
            logic [F:0]   rem;
            logic [S-1:0] q;
            logic [7:0]   nb;
            logic [F+1:0] trial;
            rem   = rem_in[s];
            q     = quo_in[s];
            nb    = nb_in[s];
            trial = '0;
            for (int j = 0; j < DIV_STEP_BITS; j++) begin
                if (s * DIV_STEP_BITS + j < S) begin
                    trial = {rem, nb[7]};
                    nb    = {nb[6:0], 1'b0};
                    if (trial >= {1'b0, d_in[s]}) begin
                        rem = (F+1)'(trial - {1'b0, d_in[s]});
                        q   = {q[S-2:0], 1'b1};
                    end else begin
                        rem = trial[F:0];
                        q   = {q[S-2:0], 1'b0};
                    end
                end
            end
            rem_next[s] = rem;
            quo_next[s] = q;
            nb_next[s]  = nb;
        end

        // valid flag
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else
            begin
                valid_reg[s] <= valid_in[s];
            end
        end

        // payload
        always_ff @(posedge clk)
        begin
            if (valid_in[s])
            begin
                rem_reg[s] <= rem_next[s];
                quo_reg[s] <= quo_next[s];
                nb_reg[s]  <= nb_next[s];
                d_reg[s]   <= d_in[s];
                fx_reg[s]  <= fx_in[s];
                fz_reg[s]  <= fz_in[s];
                lum_reg[s] <= lum_in[s];
                ovf_reg[s] <= ovf_in[s];
            end
        end
    end

    assign out_valid = valid_reg[NDIV-1];
    assign quo       = quo_reg[NDIV-1];
    assign ovf       = ovf_reg[NDIV-1];
    assign out_fx    = fx_reg[NDIV-1];
    assign out_fz    = fz_reg[NDIV-1];
    assign out_lum   = lum_reg[NDIV-1];

endmodule

// ===== design/cxs_matrix.sv =====
// ----------------------------------------------------------------------------
// cxs_matrix
// XYZ from the reciprocal, sRGB matrix, and clamp of each linear channel to
// 0..1 scaled to a gamma ROM index. Five register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cxs_matrix #(
    parameter int FRAC_BITS        = 16,
    parameter int GAMMA_INDEX_BITS = 12
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic [FRAC_BITS+7:0]           quo,
    input  logic                           ovf,
    input  logic [FRAC_BITS:0]             fx,
    input  logic signed [FRAC_BITS+1:0]    fz,
    input  logic [FRAC_BITS:0]             lum,
    output logic                           out_valid,
    output logic [2:0][GAMMA_INDEX_BITS:0] idx
);
    import cxs_pkg::*;

    localparam int F  = FRAC_BITS;
    localparam int G  = GAMMA_INDEX_BITS;
    localparam int QW = F + 8;
    localparam int CW = F + 3;
    localparam int PW = 2 * F + 12;
    localparam int SW = 2 * F + 14;

    logic [4:0]              valid_reg;

    // stage 1: reciprocal times x and z
    logic [QW-1:0]           q_sat;
    logic [2*F+8:0]          px_reg;
    logic signed [2*F+10:0]  pz_reg;
    logic [F:0]              lum1_reg;

    // stage 2: X and Z saturated to signed Q8.F
    logic signed [F+8:0]     x_next;
    logic signed [F+8:0]     z_next;
    logic signed [F+8:0]     x_reg;
    logic signed [F+8:0]     z_reg;
    logic [F:0]              lum2_reg;
    logic [F+8:0]            xs;
    logic signed [F+10:0]    zs;
    logic signed [F+1:0]     lum_s;

    // stages 3 to 5 per channel
    logic signed [PW-1:0]    prod_next [3][3];
    logic signed [PW-1:0]    prod_reg  [3][3];
    logic signed [SW-1:0]    sum_next  [3];
    logic signed [SW-1:0]    sum_reg   [3];
    logic [G:0]              idx_next  [3];
    logic [G:0]              idx_reg   [3];

    // pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    // stage 1 multipliers
    assign q_sat = ovf ? {QW{1'b1}} : quo;

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            px_reg   <= q_sat * fx;
            pz_reg   <= $signed({1'b0, q_sat}) * fz;
            lum1_reg <= lum;
        end
    end

    // stage 2 floor shift and saturation
    always_comb begin
        xs = px_reg[2*F+8:F];
        zs = pz_reg[2*F+10:F];
        if (xs[F+8]) begin
            x_next = {1'b0, {(F+8){1'b1}}};
        end else begin
            x_next = $signed(xs);
        end
        if ((zs[F+10] == zs[F+9]) && (zs[F+9] == zs[F+8])) begin
            z_next = zs[F+8:0];
        end else if (zs[F+10]) begin
            z_next = {1'b1, {(F+8){1'b0}}};
        end else begin
            z_next = {1'b0, {(F+8){1'b1}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_reg[0])
        begin
            x_reg    <= x_next;
            z_reg    <= z_next;
            lum2_reg <= lum1_reg;
        end
    end

    assign lum_s = $signed({1'b0, lum2_reg});

    for (genvar c = 0; c < 3; c++) begin : g_chan
        localparam logic signed [CW-1:0] CX = CW'(coef_q(MATRIX_TENK[3*c], F));
        localparam logic signed [CW-1:0] CY = CW'(coef_q(MATRIX_TENK[3*c+1], F));
        localparam logic signed [CW-1:0] CZ = CW'(coef_q(MATRIX_TENK[3*c+2], F));

        logic signed [F+13:0] lin;
        logic                 over;
        logic [F:0]           lin_c;

        // stage 3 coefficient products
        always_comb begin
            prod_next[c][0] = x_reg * CX;
            prod_next[c][1] = lum_s * CY;
            prod_next[c][2] = z_reg * CZ;
        end

        always_ff @(posedge clk)
        begin
            if (valid_reg[1])
            begin
                prod_reg[c][0] <= prod_next[c][0];
                prod_reg[c][1] <= prod_next[c][1];
                prod_reg[c][2] <= prod_next[c][2];
            end
        end

        // stage 4 row sum
        assign sum_next[c] = SW'(prod_reg[c][0]) + SW'(prod_reg[c][1]) + SW'(prod_reg[c][2]);

        always_ff @(posedge clk)
        begin
            if (valid_reg[2])
            begin
                sum_reg[c] <= sum_next[c];
            end
        end

        // stage 5 floor shift, clamp to 0..1, rom index
        assign lin  = sum_reg[c][SW-1:F];
        assign over = (|lin[F+12:F+1]) || (lin[F] && (|lin[F-1:0]));

        always_comb begin
            if (lin[F+13]) begin
                lin_c = '0;
            end else if (over) begin
                lin_c = {1'b1, {F{1'b0}}};
            end else begin
                lin_c = lin[F:0];
            end
        end

        if (G <= F) begin : g_idx_shr
            assign idx_next[c] = (G+1)'(lin_c >> (F - G));
        end else begin : g_idx_shl
            assign idx_next[c] = {lin_c, {(G-F){1'b0}}};
        end

        always_ff @(posedge clk)
        begin
            if (valid_reg[3])
            begin
                idx_reg[c] <= idx_next[c];
            end
        end

        assign idx[c] = idx_reg[c];
    end

    assign out_valid = valid_reg[4];

endmodule

// ===== design/cxs_gamma.sv =====
// ----------------------------------------------------------------------------
// cxs_gamma
// Gamma encode of one channel: an eight-stage binary search through the
// threshold ROM, one output bit resolved per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cxs_gamma #(
    parameter int GAMMA_INDEX_BITS = 12
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [GAMMA_INDEX_BITS:0]   idx,
    output logic                        out_valid,
    output logic [7:0]                  code
);
    import cxs_pkg::*;

    localparam int G = GAMMA_INDEX_BITS;
    localparam int N = GAMMA_CODE_BITS;

    logic          valid_reg [N];
    logic [7:0]    lo_reg    [N];
    logic [G:0]    idx_reg   [N];
    logic [7:0]    lo_next   [N];

    logic          valid_in  [N];
    logic [7:0]    lo_in     [N];
    logic [G:0]    idx_in    [N];

    for (genvar st = 0; st < N; st++) begin : g_step
        localparam logic [7:0] PROBE = 8'(1 << (N - 1 - st));

        logic [7:0]  cand;
        logic [30:0] lvl;

        if (st == 0) begin : g_first
            assign valid_in[0] = in_valid;
            assign lo_in[0]    = '0;
            assign idx_in[0]   = idx;
        end else begin : g_next
            assign valid_in[st] = valid_reg[st-1];
            assign lo_in[st]    = lo_reg[st-1];
            assign idx_in[st]   = idx_reg[st-1];
        end

        // keep the probe if its threshold is at or below the level
        assign cand = lo_in[st] | PROBE;
        assign lvl  = {idx_in[st], {(30-G){1'b0}}};
        assign lo_next[st] = (GAMMA_THR[cand] <= lvl) ? cand : lo_in[st];

        // valid flag
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[st] <= 1'b0;
            end
            else
            begin
                valid_reg[st] <= valid_in[st];
            end
        end

        // payload
        always_ff @(posedge clk)
        begin
            if (valid_in[st])
            begin
                lo_reg[st]  <= lo_next[st];
                idx_reg[st] <= idx_in[st];
            end
        end
    end

    assign out_valid = valid_reg[N-1];
    assign code      = lo_reg[N-1];

endmodule

// ===== design/cie_xy_to_srgb_core.sv =====
// ----------------------------------------------------------------------------
// cie_xy_to_srgb_core
// CIE 1931 xy plus brightness to 8-bit sRGB, fully pipelined.
// Pipeline from start to done: prescale register, reciprocal divider stages,
//   matrix stages and gamma search stages.
// Throughput: one transfer per cycle; busy is never raised and done cannot be
//   stalled by the receiver.
// Reset: rst_n clears every pipeline valid bit; items in flight are dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cie_xy_to_srgb_core #(
    parameter int FRAC_BITS        = 16,
    parameter int GAMMA_INDEX_BITS = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] chroma_x,
    input  logic [15:0] chroma_y,
    input  logic [7:0]  brightness,
    output logic        done,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue
);
    import cxs_pkg::*;

    localparam int F       = FRAC_BITS;
    localparam int G       = GAMMA_INDEX_BITS;
    localparam int NDIV    = (F + 8 + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
    localparam int LATENCY = 1 + NDIV + 5 + GAMMA_CODE_BITS;

    logic               accept;

    logic               pre_valid;
    logic [F:0]         pre_fx;
    logic [F:0]         pre_fy;
    logic [F:0]         pre_lum;

    logic               div_valid;
    logic [F+7:0]       div_quo;
    logic               div_ovf;
    logic [F:0]         div_fx;
    logic signed [F+1:0] div_fz;
    logic [F:0]         div_lum;

    logic               mtx_valid;
    logic [2:0][G:0]    mtx_idx;

    logic [2:0]         g_valid;
    logic [7:0]         g_code [3];

    // no back pressure: a transfer is taken every cycle start is high
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // fraction conversion
    cxs_prescale #(
        .FRAC_BITS (F)
    ) u_prescale (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (accept),
        .chroma_x   (chroma_x),
        .chroma_y   (chroma_y),
        .brightness (brightness),
        .out_valid  (pre_valid),
        .fx         (pre_fx),
        .fy         (pre_fy),
        .lum        (pre_lum)
    );

    // reciprocal Y / y
    cxs_div #(
        .FRAC_BITS (F)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pre_valid),
        .fx        (pre_fx),
        .fy        (pre_fy),
        .lum       (pre_lum),
        .out_valid (div_valid),
        .quo       (div_quo),
        .ovf       (div_ovf),
        .out_fx    (div_fx),
        .out_fz    (div_fz),
        .out_lum   (div_lum)
    );

    // XYZ and linear RGB
    cxs_matrix #(
        .FRAC_BITS        (F),
        .GAMMA_INDEX_BITS (G)
    ) u_matrix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid),
        .quo       (div_quo),
        .ovf       (div_ovf),
        .fx        (div_fx),
        .fz        (div_fz),
        .lum       (div_lum),
        .out_valid (mtx_valid),
        .idx       (mtx_idx)
    );

    // gamma encode, one search pipe per channel
    for (genvar c = 0; c < 3; c++) begin : g_gamma
        cxs_gamma #(
            .GAMMA_INDEX_BITS (G)
        ) u_gamma (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (mtx_valid),
            .idx       (mtx_idx[c]),
            .out_valid (g_valid[c]),
            .code      (g_code[c])
        );
    end

    assign done  = g_valid[0];
    assign red   = g_code[0];
    assign green = g_code[1];
    assign blue  = g_code[2];

    // every result traces back to a transfer exactly one latency earlier
    a_done_from_start: assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY)
    ) else $error("done without a matching start transfer");

    // the three channel pipes stay in lockstep
    a_chan_lockstep: assert property (
        @(posedge clk) disable iff (!rst_n)
        (g_valid[1] == g_valid[0]) && (g_valid[2] == g_valid[0])
    ) else $error("channel pipelines out of step");

    // a divider output is always followed by a result after the remaining stages
    a_div_to_done: assert property (
        @(posedge clk) disable iff (!rst_n)
        div_valid |-> ##(5 + GAMMA_CODE_BITS) done
    ) else $error("divider output lost before done");

endmodule

// ===== test/tb_cie_xy_to_srgb_core.sv =====
// ----------------------------------------------------------------------------
// tb_cie_xy_to_srgb_core
// Self-checking bench for the CIE xy to sRGB pipeline. A directed table covers
// zero and full brightness, the y floor, out-of-gamut corners and the primaries.
// Three random phases follow, mostly plausible chromaticities with some raw noise.
// Every result is compared in order against a fixed table color or an in-bench
// fixed-point predictor that has its own gamma threshold table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_cie_xy_to_srgb_core;

    localparam int FRAC         = 16;
    localparam int GIDX         = 12;
    localparam int Y_MIN        = 7;
    localparam int PIPE_LATENCY = 20;
    localparam int IDLE_LIMIT   = 1000;
    localparam int ITEMS_PER_PHASE = 350;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [15:0] cx;
        logic [15:0] cy;
        logic [7:0]  br;
        logic        fixed;
        rgb_t        rgb;
    } color_row_t;

    // sRGB matrix in ten-thousandths, rows R, G, B over columns X, Y, Z
    localparam int SRGB_TENK [9] = '{
        32406, -15372, -4986,
        -9689,  18758,   415,
          557,  -2040, 10570
    };

    localparam int N_DIRECTED = 23;

    // rows with fixed set use the typed color, the rest go through the predictor
    localparam color_row_t DIRECTED [N_DIRECTED] = '{
        '{16'd0,     16'd0,     8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
        '{16'd65535, 16'd65535, 8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
        '{16'd0,     16'd0,     8'd254, 1'b1, '{8'd0,   8'd255, 8'd255}},
        '{16'd65535, 16'd0,     8'd254, 1'b1, '{8'd255, 8'd0,   8'd255}},
        '{16'd20493, 16'd21561, 8'd254, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'd20493, 16'd21561, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'd20493, 16'd21561, 8'd1,   1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'd20493, 16'd6,     8'd128, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'd20493, 16'd7,     8'd128, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'd20493, 16'd8,     8'd128, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'd65535, 16'd65535, 8'd254, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'd0,     16'd65535, 8'd254, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'd41942, 16'd21626, 8'd254, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'd19661, 16'd39322, 8'd254, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'd9830,  16'd3932,  8'd254, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'd32768, 16'd32768, 8'd200, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'd21845, 16'd21845, 8'd127, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'd43690, 16'd21845, 8'd50,  1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'd10000, 16'd50000, 8'd2,   1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'd0,     16'd65535, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'd65535, 16'd0,     8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'h5555,  16'hAAAA,  8'h55,  1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'hAAAA,  16'h5555,  8'hAA,  1'b0, '{8'd0,   8'd0,   8'd0}}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [15:0] chroma_x;
    logic [15:0] chroma_y;
    logic [7:0]  brightness;
    logic        done;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;

    logic [63:0] curve_thr [256];
    rgb_t        pending_rgb [$];
    int          mismatch_count = 0;
    int          idle_cycles    = 0;

    cie_xy_to_srgb_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .chroma_x   (chroma_x),
        .chroma_y   (chroma_y),
        .brightness (brightness),
        .done       (done),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

    always #1 clk = ~clk;

    // q30 fixed-point helpers for the inverse transfer curve
    function automatic logic [63:0] q30_mul(input logic [63:0] a, input logic [63:0] b);
        return (a * b) >> 30;
    endfunction

    function automatic logic [63:0] q30_pow5(input logic [63:0] r);
        logic [63:0] r2;
        r2 = q30_mul(r, r);
        return q30_mul(q30_mul(r2, r2), r);
    endfunction

    // largest r with r^5 <= a
    function automatic logic [63:0] q30_root5(input logic [63:0] a);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        lo = 64'd0;
        hi = (64'd1 << 30) + 64'd1;
        while (hi - lo > 64'd1) begin
            mid = lo + ((hi - lo) >> 1);
            if (q30_pow5(mid) <= a) begin
                lo = mid;
            end else begin
                hi = mid;
            end
        end
        return lo;
    endfunction

    // matrix entry to Q.FRAC, rounded half up in magnitude
    function automatic longint q_coef(input int tenk);
        longint m;
        longint q;
        m = (tenk < 0) ? longint'(-tenk) : longint'(tenk);
        q = ((m << FRAC) + 64'sd5000) / 64'sd10000;
        return (tenk < 0) ? -q : q;
    endfunction

    function automatic longint sat_q8(input longint v);
        longint lim;
        lim = longint'(1) << (8 + FRAC);
        if (v < -lim) begin
            return -lim;
        end
        if (v > lim - 1) begin
            return lim - 1;
        end
        return v;
    endfunction

    // clamp a linear channel and look up its 8-bit code
    function automatic logic [7:0] curve_code(input longint lin);
        logic [63:0] idx;
        logic [63:0] l30;
        int          lo;
        int          hi;
        int          mid;
        if (lin < 0) begin
            lin = 0;
        end
        if (lin > (longint'(1) << FRAC)) begin
            lin = longint'(1) << FRAC;
        end
        if (FRAC >= GIDX) begin
            idx = 64'(lin) >> (FRAC - GIDX);
        end else begin
            idx = 64'(lin) << (GIDX - FRAC);
        end
        l30 = idx << (30 - GIDX);
        lo = 0;
        hi = 256;
        while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if (curve_thr[mid] <= l30) begin
                lo = mid;
            end else begin
                hi = mid;
            end
        end
        return 8'(lo);
    endfunction

    // expected color for one chromaticity and brightness
    function automatic rgb_t predict_rgb(input logic [15:0] cx, input logic [15:0] cy,
                                         input logic [7:0] br);
        longint fx;
        longint fy;
        longint fz;
        longint lum;
        longint recip;
        longint xs;
        longint zs;
        longint lin [3];
        rgb_t   res;
        fx    = (longint'(cx) << FRAC) / 64'sd65535;
        fy    = (longint'((cy < Y_MIN) ? 16'(Y_MIN) : cy) << FRAC) / 64'sd65535;
        fz    = (longint'(1) << FRAC) - fx - fy;
        lum   = (longint'(br) << FRAC) / 64'sd254;
        recip = (lum << FRAC) / fy;
        if (recip > (longint'(1) << (8 + FRAC)) - 1) begin
            recip = (longint'(1) << (8 + FRAC)) - 1;
        end
        xs = sat_q8((recip * fx) >>> FRAC);
        zs = sat_q8((recip * fz) >>> FRAC);
        for (int ch = 0; ch < 3; ch++) begin
            lin[ch] = (xs * q_coef(SRGB_TENK[3 * ch]) + lum * q_coef(SRGB_TENK[3 * ch + 1])
                       + zs * q_coef(SRGB_TENK[3 * ch + 2])) >>> FRAC;
        end
        res.red   = curve_code(lin[0]);
        res.green = curve_code(lin[1]);
        res.blue  = curve_code(lin[2]);
        return res;
    endfunction

    // present one color, idling first at the given rate, and log its expectation
    task automatic send_color(input logic [15:0] cx, input logic [15:0] cy,
                              input logic [7:0] br, input int idle_pct,
                              input logic fixed, input rgb_t fixed_rgb);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        chroma_x   <= cx;
        chroma_y   <= cy;
        brightness <= br;
        @(posedge clk);
        while (busy) begin
            @(posedge clk);
        end
        pending_rgb.push_back(fixed ? fixed_rgb : predict_rgb(cx, cy, br));
    endtask

    // mostly plausible chromaticities, the rest raw noise, tiny y and corners
    task automatic send_random(input int idle_pct);
        logic [15:0] cx;
        logic [15:0] cy;
        logic [7:0]  br;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 60) begin
            cx = 16'($urandom_range(48000, 3000));
            cy = 16'($urandom_range(56000, 1500));
            if (32'(cx) + 32'(cy) > 32'd65535) begin
                cy = 16'(65535 - 32'(cx) - $urandom_range(1000));
            end
        end else if (pick < 80) begin
            cx = 16'($urandom);
            cy = 16'($urandom);
        end else if (pick < 90) begin
            cx = 16'($urandom);
            cy = 16'($urandom_range(15));
        end else begin
            cx = $urandom_range(1) ? 16'($urandom_range(65535, 65500)) : 16'($urandom_range(40));
            cy = $urandom_range(1) ? 16'($urandom_range(65535, 65500)) : 16'($urandom_range(40));
        end
        case ($urandom_range(9))
            0: br = 8'd0;
            1: br = 8'd1;
            2: br = 8'd254;
            3: br = 8'd255;
            default: br = 8'($urandom);
        endcase
        send_color(cx, cy, br, idle_pct, 1'b0, '0);
    endtask

    // result checking and watchdog
    always @(posedge clk) begin
        rgb_t exp_rgb;
        if (rst_n) begin
            if ((start && !busy) || done) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
            if (done) begin
                if (pending_rgb.size() == 0) begin
                    if (mismatch_count < 10) begin
                        $display("unexpected result rgb %0d %0d %0d", red, green, blue);
                    end
                    mismatch_count <= mismatch_count + 1;
                end else begin
                    exp_rgb = pending_rgb.pop_front();
                    if (red !== exp_rgb.red || green !== exp_rgb.green
                        || blue !== exp_rgb.blue) begin
                        if (mismatch_count < 10) begin
                            $display("mismatch: expected rgb %0d %0d %0d, got %0d %0d %0d",
                                     exp_rgb.red, exp_rgb.green, exp_rgb.blue,
                                     red, green, blue);
                        end
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
        end
    end

    // stimulus
    initial begin
        int idle_pct [3];
        logic [63:0] u;
        logic [63:0] u2;
        idle_pct = '{27, 63, 0};
        start      <= 1'b0;
        chroma_x   <= '0;
        chroma_y   <= '0;
        brightness <= '0;
        rst_n      <= 1'b0;

        // threshold of each output code on the linear axis, q30
        curve_thr[0] = 64'd0;
        for (int v = 1; v < 256; v++) begin
            if (v <= 10) begin
                curve_thr[v] = ((64'(v) * 64'd10) << 30) / 64'd32946;
            end else begin
                u  = ((64'd1000 * 64'(v) + 64'd14025) << 30) / 64'd269025;
                u2 = q30_mul(u, u);
                curve_thr[v] = q30_mul(u2, q30_root5(u2));
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int n = 0; n < N_DIRECTED; n++) begin
            send_color(DIRECTED[n].cx, DIRECTED[n].cy, DIRECTED[n].br, idle_pct[0],
                       DIRECTED[n].fixed, DIRECTED[n].rgb);
        end

        // random phases, draining the pipe before each one
        for (int ph = 0; ph < 3; ph++) begin
            start <= 1'b0;
            @(posedge clk);
            while (pending_rgb.size() != 0) begin
                @(posedge clk);
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_random(idle_pct[ph]);
            end
        end
        start <= 1'b0;
        @(posedge clk);
        while (pending_rgb.size() != 0) begin
            @(posedge clk);
        end
        repeat (3 * PIPE_LATENCY) @(posedge clk);

        if (mismatch_count == 0 && pending_rgb.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/cxs_pkg.sv
design/cxs_prescale.sv
design/cxs_div.sv
design/cxs_matrix.sv
design/cxs_gamma.sv
design/cie_xy_to_srgb_core.sv
test/tb_cie_xy_to_srgb_core.sv
